[hdl/multichannel_block_averager_defines.svh]
// Assertion macros shared by the block averager modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MULTICHANNEL_BLOCK_AVERAGER_DEFINES_SVH
`define MULTICHANNEL_BLOCK_AVERAGER_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define MCBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define MCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mcba_pkg.sv]
package mcba_pkg;

  // Fixed field widths of the sample and result transfers.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CHAN_OUT_W = 3;
  localparam int unsigned AVG_W      = 12;
  localparam int unsigned SCAN_CNT_W = 32;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Controls from the sequencer to the channel store.
  typedef struct packed {
    logic sample_en;
    logic emit_sel;
    logic clear;
  } acc_ctrl_t;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hdl/mcba_divider.sv]
`include "multichannel_block_averager_defines.svh"

// Division by a constant through multiplication with a rounded-up reciprocal.
// The dividend is taken in on start, the product is formed in the following cycle,
// and the quotient is registered in the cycle after that.
module mcba_divider #(
  parameter int unsigned DIVIDEND_W = 16,
  parameter int unsigned DIVISOR    = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DIVIDEND_W-1:0]   dividend_i,
  output logic [DIVIDEND_W-1:0]   quotient_o,
  output mcba_pkg::div_status_t   status_o
);

  // With the shift set to DIVIDEND_W plus the ceiling of log2 of the divisor and the reciprocal
  // rounded up, the truncated product is the exact quotient for every dividend.
  localparam int unsigned LOG_D   = $clog2(DIVISOR);
  localparam int unsigned SHIFT   = DIVIDEND_W + LOG_D;
  localparam int unsigned RECIP_W = DIVIDEND_W + 1;
  localparam int unsigned PROD_W  = DIVIDEND_W + RECIP_W;
  localparam longint unsigned RecipVal =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] Recip = RECIP_W'(RecipVal);

  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic                  busy_q;
  logic                  done_q;
  logic [PROD_W-1:0]     product;

  assign product = PROD_W'(dvd_q) * PROD_W'(Recip);

  always_comb begin
    dvd_d = dvd_q;
    quo_d = quo_q;
    if (start_i) begin
      dvd_d = dividend_i;
    end
    if (busy_q) begin
      quo_d = DIVIDEND_W'(product >> SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

  `MCBA_ASSERT(a_start_idle, start_i |-> !busy_q, "divider started while busy")
  `MCBA_ASSERT_NEXT(a_start_busy, start_i, busy_q && !done_q, "divider did not take the dividend")
  `MCBA_ASSERT(a_done_excl, done_q |-> !busy_q, "done raised while still busy")

endmodule

[hdl/mcba_accum.sv]
// Per-channel running sums, latest samples, scan position and scan counter.
module mcba_accum #(
  parameter int unsigned CHANNELS    = 6,
  parameter int unsigned SCANS       = 16,
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned SUM_W       = 16,
  parameter int unsigned CH_W        = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mcba_pkg::acc_ctrl_t                ctrl_i,
  input  logic [mcba_pkg::SAMPLE_W-1:0]      sample_i,
  input  logic [CH_W-1:0]                    rd_ch_i,
  output logic [SUM_W-1:0]                   sum_o,
  output logic [mcba_pkg::SAMPLE_W-1:0]      latest_o,
  output logic [mcba_pkg::SCAN_CNT_W-1:0]    scan_total_o,
  output logic                               block_end_o
);

  localparam int unsigned SW   = mcba_pkg::SAMPLE_W;
  localparam int unsigned SP_W = $clog2(SCANS + 1);
  localparam logic [SW-1:0] SampleMask =
    (SAMPLE_BITS >= SW) ? {SW{1'b1}} : SW'((32'd1 << SAMPLE_BITS) - 32'd1);

  logic [SUM_W-1:0]                sums_q [CHANNELS];
  logic [SW-1:0]                   latest_q [CHANNELS];
  logic [CH_W-1:0]                 chan_pos_q, chan_pos_d;
  logic [SP_W-1:0]                 scan_pos_q, scan_pos_d;
  logic [mcba_pkg::SCAN_CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [CH_W-1:0]                 rd_sel;
  logic [SW-1:0]                   sample_m;
  logic                            scan_end;

  assign sample_m = sample_i & SampleMask;
  assign rd_sel   = ctrl_i.emit_sel ? rd_ch_i : chan_pos_q;
  assign sum_o    = sums_q[rd_sel];
  assign latest_o = latest_q[rd_sel];
  assign scan_end = (chan_pos_q == CH_W'(CHANNELS - 1));
  assign block_end_o = scan_end && (scan_pos_q == SP_W'(SCANS - 1));

  always_comb begin
    chan_pos_d = chan_pos_q;
    scan_pos_d = scan_pos_q;
    scan_cnt_d = scan_cnt_q;
    if (ctrl_i.sample_en) begin
      if (scan_end) begin
        chan_pos_d = '0;
        scan_cnt_d = scan_cnt_q + 32'd1;
        scan_pos_d = block_end_o ? '0 : scan_pos_q + SP_W'(1);
      end else begin
        chan_pos_d = chan_pos_q + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_pos_q <= '0;
      scan_pos_q <= '0;
      scan_cnt_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sums_q[i] <= '0;
      end
    end else begin
      chan_pos_q <= chan_pos_d;
      scan_pos_q <= scan_pos_d;
      scan_cnt_q <= scan_cnt_d;
      if (ctrl_i.clear) begin
        for (int i = 0; i < CHANNELS; i++) begin
          sums_q[i] <= '0;
        end
      end else if (ctrl_i.sample_en) begin
        sums_q[chan_pos_q] <= sum_o + SUM_W'(sample_m);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sample_en) begin
      latest_q[chan_pos_q] <= sample_m;
    end
  end

  assign scan_total_o = scan_cnt_q;

endmodule

[hdl/multichannel_block_averager.sv]
// Sequence: a sample that is not the last of its block is taken in and gives no result;
// after the block's final sample the sequencer walks the channels in order through LOAD,
// DIV and EMIT, presenting one result per channel, and waits in EMIT while the output stalls.
// Throughput: one sample per cycle inside a block; the input stalls at block end while the
// one shared divider serves every channel, plus any output stall.
// Reset: rst_ni clears positions, sums, scan counter, sequencer and output valid at once.
`include "multichannel_block_averager_defines.svh"

module multichannel_block_averager #(
  parameter int unsigned CHANNELS    = 6,
  parameter int unsigned SCANS       = 16,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mcba_pkg::SAMPLE_W-1:0]       sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mcba_pkg::CHAN_OUT_W-1:0]     channel_o,
  output logic [mcba_pkg::AVG_W-1:0]          average_o,
  output logic [mcba_pkg::SAMPLE_W-1:0]       raw_value_o,
  output logic [mcba_pkg::SCAN_CNT_W-1:0]     scan_total_o,
  output logic                                last_o
);

  // A block sum never exceeds SCANS times the largest sample.
  localparam int unsigned SUM_W = mcba_pkg::SAMPLE_W + $clog2(SCANS);
  localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  mcba_pkg::state_e      state_q, state_d;
  logic [CH_W-1:0]       ch_idx_q, ch_idx_d;
  mcba_pkg::acc_ctrl_t   acc_ctrl;
  mcba_pkg::div_status_t div_status;
  logic [SUM_W-1:0]      sum_rd;
  logic [SUM_W-1:0]      quotient;
  logic [mcba_pkg::SAMPLE_W-1:0]   latest_rd;
  logic [mcba_pkg::SCAN_CNT_W-1:0] scan_total;
  logic                  block_end;
  logic                  in_accept;
  logic                  div_start;
  logic                  out_free;
  logic                  out_load;
  logic                  last_ch;

  logic                                out_valid_q, out_valid_d;
  logic [mcba_pkg::CHAN_OUT_W-1:0]     out_channel_q;
  logic [mcba_pkg::AVG_W-1:0]          out_average_q;
  logic [mcba_pkg::SAMPLE_W-1:0]       out_raw_q;
  logic [mcba_pkg::SCAN_CNT_W-1:0]     out_scan_q;
  logic                                out_last_q;

  // Samples are only taken while the sequencer is idle; the block end burst
  // holds the input off until its last result sits in the output register.
  assign in_stall_o = (state_q != mcba_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The output register frees up when empty or when its transfer completes.
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_ch  = (ch_idx_q == CH_W'(CHANNELS - 1));
  assign out_load = (state_q == mcba_pkg::ST_EMIT) && out_free;
  assign div_start = (state_q == mcba_pkg::ST_LOAD);

  always_comb begin
    acc_ctrl.sample_en = in_accept;
    acc_ctrl.emit_sel  = (state_q != mcba_pkg::ST_IDLE);
    // Sums clear once the highest channel's average has been taken.
    acc_ctrl.clear     = out_load && last_ch;
  end

  // Sequencer: walks the channels once per block end, reusing one divider.
  always_comb begin
    state_d  = state_q;
    ch_idx_d = ch_idx_q;
    unique case (state_q)
      mcba_pkg::ST_IDLE: begin
        if (in_accept && block_end) begin
          state_d  = mcba_pkg::ST_LOAD;
          ch_idx_d = '0;
        end
      end
      mcba_pkg::ST_LOAD: begin
        state_d = mcba_pkg::ST_DIV;
      end
      mcba_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_d = mcba_pkg::ST_EMIT;
        end
      end
      mcba_pkg::ST_EMIT: begin
        if (out_free) begin
          if (last_ch) begin
            state_d = mcba_pkg::ST_IDLE;
          end else begin
            state_d  = mcba_pkg::ST_LOAD;
            ch_idx_d = ch_idx_q + CH_W'(1);
          end
        end
      end
      default: begin
        state_d = mcba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mcba_pkg::ST_IDLE;
      ch_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_idx_q    <= ch_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload; the scan counter does not move during the burst.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_channel_q <= mcba_pkg::CHAN_OUT_W'(ch_idx_q);
      out_average_q <= quotient[mcba_pkg::AVG_W-1:0];
      out_raw_q     <= latest_rd;
      out_scan_q    <= scan_total;
      out_last_q    <= last_ch;
    end
  end

  mcba_accum #(
    .CHANNELS    (CHANNELS),
    .SCANS       (SCANS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .CH_W        (CH_W)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (acc_ctrl),
    .sample_i     (sample_i),
    .rd_ch_i      (ch_idx_q),
    .sum_o        (sum_rd),
    .latest_o     (latest_rd),
    .scan_total_o (scan_total),
    .block_end_o  (block_end)
  );

  mcba_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR    (SCANS)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_rd),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  assign out_valid_o  = out_valid_q;
  assign channel_o    = out_channel_q;
  assign average_o    = out_average_q;
  assign raw_value_o  = out_raw_q;
  assign scan_total_o = out_scan_q;
  assign last_o       = out_last_q;

  `MCBA_ASSERT(a_busy_in_div, div_status.busy |-> state_q == mcba_pkg::ST_DIV, "divider busy outside the divide state")
  `MCBA_ASSERT(a_done_in_div, div_status.done |-> state_q == mcba_pkg::ST_DIV, "divider finished outside the divide state")
  `MCBA_ASSERT_NEXT(a_last_idle, out_load && last_ch, state_q == mcba_pkg::ST_IDLE && out_last_q && out_valid_q, "burst did not end on the highest channel")

endmodule
